// File: hdl/aeai_pkg.sv
// Package for the absolute encoder angle identification block.
// Holds item types, phase and sequencer encodings, register indexes and constants.
// No dependencies.
`timescale 1ns / 1ps
package aeai_pkg;

  // Shared divider sizing
  localparam int AEAI_DVD_W = 32;
  localparam int AEAI_DVS_W = 24;

  // Configuration register indexes
  localparam logic [2:0] REG_COUNTS_PER_REV   = 3'd0;
  localparam logic [2:0] REG_POLE_PAIRS       = 3'd1;
  localparam logic [2:0] REG_TICKS_PER_SECOND = 3'd2;
  localparam logic [2:0] REG_CURRENT_LIMIT    = 3'd3;
  localparam logic [2:0] REG_ANGLE_TURN_COUNT = 3'd4;
  localparam logic [2:0] REG_REVERSE_DIR      = 3'd5;
  localparam logic [2:0] REG_WIRING_CHECK_ON  = 3'd6;
  localparam logic [2:0] REG_CTRL_BASE        = 3'd7;

  // Configuration reset values
  localparam logic [23:0] RST_COUNTS_PER_REV   = 24'd1048576;
  localparam logic [6:0]  RST_POLE_PAIRS       = 7'd4;
  localparam logic [15:0] RST_TICKS_PER_SECOND = 16'd16000;
  localparam logic [15:0] RST_CURRENT_LIMIT    = 16'd1000;
  localparam logic [15:0] RST_ANGLE_TURN_COUNT = 16'd65535;
  localparam logic        RST_REVERSE_DIR      = 1'b0;
  localparam logic        RST_WIRING_CHECK_ON  = 1'b1;
  localparam logic [15:0] RST_CTRL_BASE        = 16'd0;

  // Status codes
  localparam logic [1:0] SERVO_READY = 2'd1;
  localparam logic [1:0] SERVO_RUN   = 2'd2;
  localparam logic [1:0] SAVE_DONE   = 2'd1;
  localparam logic [1:0] SAVE_FAIL   = 2'd2;
  localparam logic [1:0] OC_BUSY     = 2'd0;
  localparam logic [1:0] OC_SUCCESS  = 2'd1;
  localparam logic [1:0] OC_WIRING   = 2'd2;
  localparam logic [1:0] OC_FAIL     = 2'd3;

  // Arithmetic constants
  localparam logic [23:0] ENC23_COUNTS    = 24'h800000;
  localparam logic [16:0] FULL_TURN       = 17'd65536;
  localparam logic [11:0] TENTHS_PER_TURN = 12'd3600;
  // x / 6 for any 16-bit x is (x * RECIP_SIX) >> 18
  localparam logic [15:0] RECIP_SIX       = 16'd43691;
  localparam logic [15:0] CTRL_OVERRIDE   = 16'h0002;
  localparam logic [15:0] RAMP_STEP       = 16'd2;

  typedef enum logic [2:0] {
    PH_WAIT_READY = 3'd0,
    PH_SET_CTRL   = 3'd1,
    PH_WAIT_RUN   = 3'd2,
    PH_ALIGN      = 3'd3,
    PH_RAMP_DOWN  = 3'd4,
    PH_ENC_WRITE  = 3'd5,
    PH_DONE_OK    = 3'd6,
    PH_DONE_FAIL  = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_HALF,
    SQ_DIVP,
    SQ_MOD,
    SQ_INIT,
    SQ_APPLY
  } seq_t;

  typedef struct packed {
    logic [1:0]  servo_state;
    logic [22:0] abs_position;
    logic [1:0]  save_status;
  } in_item_t;

  typedef struct packed {
    logic [15:0] ctrl_word;
    logic        pos_reset;
    logic [15:0] d_current_ref;
    logic [15:0] angle_command;
    logic        angle_write;
    logic        ident_active;
    logic [15:0] offset_counts;
    logic [11:0] init_angle_tenths;
    logic        params_save;
    logic        encoder_write_req;
    logic [1:0]  outcome;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [23:0] wdata;
  } cfg_item_t;

endpackage

// File: hdl/aeai_chan_if.sv
// Valid/ready channel interface carrying one payload item.
// Payload type is supplied per instance, normally from aeai_pkg.
`timescale 1ns / 1ps
interface aeai_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/abs_encoder_angle_ident.sv
// Absolute encoder electrical angle identification sequencer, one item per control tick.
// Takes one item at a time: a new input item is accepted only once the result of the
// last one has been loaded into the output register. Divisions run on the shared
// 32-bit divider, and a stalled result holds the sequencer.
// Reset (rst, synchronous): phase wait-for-ready, sequence state, held values and
// configuration registers to their defaults. Depends on aeai_pkg, aeai_chan_if, aeai_div.
`timescale 1ns / 1ps
module abs_encoder_angle_ident #(
  parameter int DVD_W = aeai_pkg::AEAI_DVD_W,
  parameter int DVS_W = aeai_pkg::AEAI_DVS_W
) (
  input logic  clk,
  input logic  rst,
  aeai_chan_if.sink   in_ch,
  aeai_chan_if.source out_ch,
  aeai_chan_if.sink   cfg_ch
);
  import aeai_pkg::*;

  // Configuration registers
  logic [23:0] counts_per_rev;
  logic [6:0]  pole_pairs;
  logic [15:0] ticks_per_second;
  logic [15:0] current_limit;
  logic [15:0] angle_turn_count;
  logic        reverse_dir;
  logic        wiring_check_on;
  logic [15:0] ctrl_base;

  // Sequence state
  phase_t      phase, phase_next;
  logic [19:0] tick_count, tick_next;
  logic [22:0] half_turn_counts, half_next;
  logic [15:0] current_angle, angle_next;
  logic [22:0] first_position, first_next;
  logic [22:0] second_position, second_next;
  logic        wiring_error, werr_next;
  logic [15:0] d_ref_value, dref_next;
  logic [15:0] angle_reg, areg_next;
  logic        active_flag, active_next;
  logic [15:0] offset_hold, offset_next;
  logic [11:0] init_hold, init_next;

  // Item sequencer
  seq_t        sq, sq_next;
  logic        fresh;
  in_item_t    cap;
  logic        commit;
  logic        out_valid;
  out_item_t   out_data, out_next;

  // Division results
  logic [22:0] half_res;
  logic [15:0] six_res;
  logic [15:0] twelve_res;
  logic [16:0] divp_res;
  logic [15:0] tmod_res;
  logic [11:0] init_res;

  // Divider hookup
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  // Derived values
  logic [6:0]  pp_eff;
  logic [17:0] t3;
  logic [18:0] t6;
  logic [19:0] t9;
  logic [20:0] tick_inc;
  logic [15:0] t_sel;
  logic signed [24:0] dpos;
  logic signed [24:0] hturn;
  logic        werr_new;
  logic        in_t3, in_t6, at_t6, in_t9, at_t9, finish;
  logic [16:0] dref_sum;
  logic [15:0] angle_dec;
  logic [31:0] six_prod;
  logic        in_accept;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign pp_eff    = (pole_pairs == 7'd0) ? 7'd1 : pole_pairs;
  assign t3        = {ticks_per_second, 1'b0} + 18'(ticks_per_second);
  assign t6        = {t3, 1'b0};
  assign t9        = 20'(t6) + 20'(t3);
  assign tick_inc  = 21'(tick_count) + 21'd1;
  assign dref_sum  = 17'(d_ref_value) + 17'(RAMP_STEP);
  assign angle_dec = current_angle - 16'd1;

  // Sixth and twelfth of the turn count by reciprocal multiplication
  assign six_prod   = 32'(angle_turn_count) * 32'(RECIP_SIX);
  assign six_res    = {2'b00, six_prod[31:18]};
  assign twelve_res = {3'b000, six_prod[31:19]};

  // Alignment timing regions
  always_comb begin
    in_t3  = tick_count < 20'(t3);
    in_t6  = tick_count < 20'(t6);
    at_t6  = tick_count == 20'(t6);
    in_t9  = tick_count < t9;
    at_t9  = tick_count == t9;
    finish = !in_t3 && !in_t6 && !at_t6 && !in_t9 && !at_t9;
  end

  // Phase order check from the two samples
  always_comb begin
    dpos  = 25'(second_position) - 25'(first_position);
    hturn = 25'(half_turn_counts);
    werr_new = wiring_error;
    if (wiring_check_on) begin
      if (!reverse_dir && ((dpos > 0 && dpos < hturn) || (-dpos > hturn))) werr_new = 1'b1;
      if (reverse_dir && ((-dpos > 0 && -dpos < hturn) || (dpos > hturn))) werr_new = 1'b1;
    end
  end

  // Offset extraction from the captured position
  always_comb begin
    t_sel = (counts_per_rev == ENC23_COUNTS) ? cap.abs_position[22:7]
                                             : cap.abs_position[19:4];
    if (reverse_dir) t_sel = ~t_sel;
  end

  // Configuration writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev   <= RST_COUNTS_PER_REV;
      pole_pairs       <= RST_POLE_PAIRS;
      ticks_per_second <= RST_TICKS_PER_SECOND;
      current_limit    <= RST_CURRENT_LIMIT;
      angle_turn_count <= RST_ANGLE_TURN_COUNT;
      reverse_dir      <= RST_REVERSE_DIR;
      wiring_check_on  <= RST_WIRING_CHECK_ON;
      ctrl_base        <= RST_CTRL_BASE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.reg_index)
        REG_COUNTS_PER_REV:   counts_per_rev   <= cfg_ch.data.wdata;
        REG_POLE_PAIRS:       pole_pairs       <= cfg_ch.data.wdata[6:0];
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_ch.data.wdata[15:0];
        REG_CURRENT_LIMIT:    current_limit    <= cfg_ch.data.wdata[15:0];
        REG_ANGLE_TURN_COUNT: angle_turn_count <= cfg_ch.data.wdata[15:0];
        REG_REVERSE_DIR:      reverse_dir      <= cfg_ch.data.wdata[0];
        REG_WIRING_CHECK_ON:  wiring_check_on  <= cfg_ch.data.wdata[0];
        REG_CTRL_BASE:        ctrl_base        <= cfg_ch.data.wdata[15:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state
  always_comb begin
    sq_next = sq;
    case (sq)
      SQ_IDLE: begin
        if (in_accept) begin
          if (phase == PH_WAIT_READY && in_ch.data.servo_state == SERVO_READY)
            sq_next = SQ_HALF;
          else if (phase == PH_ALIGN && finish && !werr_new) sq_next = SQ_DIVP;
          else sq_next = SQ_APPLY;
        end
      end
      SQ_HALF:   if (div_done) sq_next = SQ_APPLY;
      SQ_DIVP:   if (div_done) sq_next = SQ_MOD;
      SQ_MOD:    if (div_done) sq_next = SQ_INIT;
      SQ_INIT:   if (div_done) sq_next = SQ_APPLY;
      SQ_APPLY:  if (!out_valid || out_ch.ready) sq_next = SQ_IDLE;
      default:   sq_next = SQ_IDLE;
    endcase
  end

  // Sequencer outputs: input ready, commit, divider operands and start
  always_comb begin
    div_dvd   = '0;
    div_dvs   = '0;
    in_ch.ready = (sq == SQ_IDLE);
    commit    = (sq == SQ_APPLY) && (!out_valid || out_ch.ready);
    case (sq)
      SQ_HALF: begin
        div_dvd = DVD_W'(counts_per_rev);
        div_dvs = DVS_W'({pp_eff, 1'b0});
      end
      SQ_DIVP: begin
        div_dvd = DVD_W'(FULL_TURN);
        div_dvs = DVS_W'(pp_eff);
      end
      SQ_MOD: begin
        div_dvd = DVD_W'(t_sel);
        div_dvs = DVS_W'(divp_res);
      end
      SQ_INIT: begin
        div_dvd = DVD_W'(tmod_res) * DVD_W'(TENTHS_PER_TURN) + DVD_W'(divp_res[16:1]);
        div_dvs = DVS_W'(divp_res);
      end
      default: ;
    endcase
    div_start = fresh && (sq == SQ_HALF || sq == SQ_DIVP || sq == SQ_MOD ||
                          sq == SQ_INIT);
  end

  aeai_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  // Sequencer registers and item capture
  always_ff @(posedge clk) begin
    if (rst) begin
      sq    <= SQ_IDLE;
      fresh <= 1'b0;
    end else begin
      sq    <= sq_next;
      fresh <= (sq_next != sq);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) cap <= in_ch.data;
  end

  // Keep division results
  always_ff @(posedge clk) begin
    if (div_done) begin
      case (sq)
        SQ_HALF:   half_res   <= div_quo[22:0];
        SQ_DIVP:   divp_res   <= div_quo[16:0];
        SQ_MOD:    tmod_res   <= div_rem[15:0];
        SQ_INIT:   init_res   <= div_quo[11:0];
        default: ;
      endcase
    end
  end

  // One control tick of the identification sequence
  always_comb begin
    phase_next  = phase;
    tick_next   = tick_count;
    half_next   = half_turn_counts;
    angle_next  = current_angle;
    first_next  = first_position;
    second_next = second_position;
    werr_next   = wiring_error;
    dref_next   = d_ref_value;
    areg_next   = angle_reg;
    active_next = active_flag;
    offset_next = offset_hold;
    init_next   = init_hold;
    out_next    = '0;
    case (phase)
      PH_WAIT_READY: begin
        if (cap.servo_state == SERVO_READY) begin
          half_next  = half_res;
          phase_next = PH_SET_CTRL;
        end
      end
      PH_SET_CTRL: begin
        dref_next  = '0;
        phase_next = PH_WAIT_RUN;
      end
      PH_WAIT_RUN: begin
        active_next = 1'b1;
        if (cap.servo_state == SERVO_RUN) phase_next = PH_ALIGN;
      end
      PH_ALIGN: begin
        if (tick_count[3:0] == 4'd0 && d_ref_value < current_limit)
          dref_next = dref_sum[16] ? 16'hffff : dref_sum[15:0];
        if (in_t3) begin
          tick_next = tick_inc[19:0];
          angle_next = six_res;
          areg_next = six_res;
          out_next.angle_write = 1'b1;
        end else if (in_t6) begin
          tick_next = tick_inc[19:0];
          if (current_angle > twelve_res && tick_inc[1:0] == 2'd0) angle_next = angle_dec;
          areg_next = angle_next;
          out_next.angle_write = 1'b1;
        end else if (at_t6) begin
          tick_next  = tick_inc[19:0];
          first_next = cap.abs_position;
        end else if (in_t9) begin
          tick_next = tick_inc[19:0];
          if (current_angle != 16'd0 && tick_inc[1:0] == 2'd0) angle_next = angle_dec;
          areg_next = angle_next;
          out_next.angle_write = 1'b1;
        end else if (at_t9) begin
          tick_next   = tick_inc[19:0];
          second_next = cap.abs_position;
        end else begin
          werr_next = werr_new;
          if (!werr_new) begin
            offset_next = tmod_res;
            init_next   = init_res;
          end
          phase_next  = PH_RAMP_DOWN;
          tick_next   = '0;
          angle_next  = '0;
          first_next  = '0;
          second_next = '0;
        end
      end
      PH_RAMP_DOWN: begin
        if (d_ref_value != 16'd0) begin
          dref_next = (d_ref_value >= RAMP_STEP) ? d_ref_value - RAMP_STEP : 16'd0;
        end else begin
          active_next = 1'b0;
          if (cap.servo_state != SERVO_RUN) begin
            tick_next = '0;
            if (!wiring_error) begin
              out_next.params_save = 1'b1;
              areg_next  = offset_hold;
              out_next.angle_write = 1'b1;
              phase_next = PH_ENC_WRITE;
            end else begin
              phase_next = PH_DONE_FAIL;
            end
          end
        end
      end
      PH_ENC_WRITE: begin
        out_next.encoder_write_req = 1'b1;
        if (cap.save_status == SAVE_DONE) phase_next = PH_DONE_OK;
        else if (cap.save_status == SAVE_FAIL) phase_next = PH_DONE_FAIL;
      end
      default: begin
        if (phase == PH_DONE_OK) out_next.outcome = OC_SUCCESS;
        else if (wiring_error) out_next.outcome = OC_WIRING;
        else out_next.outcome = OC_FAIL;
        werr_next  = 1'b0;
        phase_next = PH_WAIT_READY;
      end
    endcase
    out_next.ctrl_word = (phase_next inside {PH_WAIT_RUN, PH_ALIGN, PH_RAMP_DOWN,
                                             PH_ENC_WRITE}) ? (ctrl_base | CTRL_OVERRIDE)
                                                            : ctrl_base;
    out_next.pos_reset = phase_next inside {PH_SET_CTRL, PH_WAIT_RUN, PH_ALIGN,
                                            PH_RAMP_DOWN, PH_ENC_WRITE};
    out_next.d_current_ref     = dref_next;
    out_next.angle_command     = areg_next;
    out_next.ident_active      = active_next;
    out_next.offset_counts     = offset_next;
    out_next.init_angle_tenths = init_next;
  end

  // Commit the tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_WAIT_READY;
      tick_count       <= '0;
      half_turn_counts <= '0;
      current_angle    <= '0;
      first_position   <= '0;
      second_position  <= '0;
      wiring_error     <= 1'b0;
      d_ref_value      <= '0;
      angle_reg        <= '0;
      active_flag      <= 1'b0;
      offset_hold      <= '0;
      init_hold        <= '0;
    end else if (commit) begin
      phase            <= phase_next;
      tick_count       <= tick_next;
      half_turn_counts <= half_next;
      current_angle    <= angle_next;
      first_position   <= first_next;
      second_position  <= second_next;
      wiring_error     <= werr_next;
      d_ref_value      <= dref_next;
      angle_reg        <= areg_next;
      active_flag      <= active_next;
      offset_hold      <= offset_next;
      init_hold        <= init_next;
    end
  end

  // Output register: load on commit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_data <= out_next;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in work");

  a_outcome_returns_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.outcome != OC_BUSY |-> phase == PH_WAIT_READY)
    else $error("finished outcome without return to wait-for-ready");

  a_div_done_in_div_step: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (sq == SQ_HALF || sq == SQ_DIVP || sq == SQ_MOD || sq == SQ_INIT))
    else $error("divider finished outside a division step");

endmodule

// File: hdl/aeai_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on no package; widths come from parameters.
`timescale 1ns / 1ps
module aeai_div #(
  parameter int DVD_W = 32,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[DVD_W-1]};
    diff    = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // Control: load on start, count down one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], fits};
      rem <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
endmodule

// File: tb/aeai_checker.sv
// Checker for the encoder angle identification block: watches input, result and
// register channels, predicts each result item and compares it as a whole item.
// Depends on aeai_pkg.
`timescale 1ns / 1ps
module aeai_checker
  import aeai_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_fire,
  input in_item_t in_item,
  input logic out_fire,
  input out_item_t out_item,
  input logic cfg_fire,
  input cfg_item_t cfg_item,
  output int fail_count,
  output int pending,
  output int tick_total,
  output int outcome_seen[4]
);

  // configuration copy
  logic [23:0] cpr;
  logic [6:0]  poles;
  logic [15:0] tps, ilim, aturn, cbase;
  logic        rev, wchk;

  // sequence state copy
  phase_t      ph;
  logic [19:0] tcnt;
  logic [22:0] half_cnt, pos_a, pos_b;
  logic [15:0] cur_ang, dref, ang_reg, off_hold;
  logic [11:0] init_hold;
  logic        werr, act;

  out_item_t tick_results[$];

  function automatic logic [31:0] eff_poles();
    return (poles == 0) ? 32'd1 : {25'd0, poles};
  endfunction

  // evaluate one control tick and advance the predicted state
  task automatic run_tick(input in_item_t it, output out_item_t r);
    logic [1:0]  sv, sav;
    logic [22:0] pos;
    logic        aw, ps, er;
    logic [1:0]  oc;
    logic [31:0] t3, t6, t9, dv, t, tc;
    int          dd, hh;
    sv = it.servo_state; pos = it.abs_position; sav = it.save_status;
    aw = 0; ps = 0; er = 0; oc = OC_BUSY;
    t3 = 3 * tps; t6 = 6 * tps; t9 = 9 * tps;
    case (ph)
      PH_WAIT_READY: if (sv == SERVO_READY) begin
        half_cnt = 23'(({8'd0, cpr}) / (eff_poles() * 2));
        ph = PH_SET_CTRL;
      end
      PH_SET_CTRL: begin
        dref = 0; ph = PH_WAIT_RUN;
      end
      PH_WAIT_RUN: begin
        act = 1;
        if (sv == SERVO_RUN) ph = PH_ALIGN;
      end
      PH_ALIGN: begin
        tc = {12'd0, tcnt};
        if (tc[3:0] == 0 && dref < ilim)
          dref = (dref >= 16'hfffe) ? 16'hffff : dref + RAMP_STEP;
        if (tc < t3) begin
          tc++; cur_ang = aturn / 6; ang_reg = cur_ang; aw = 1;
        end else if (tc < t6) begin
          tc++;
          if (cur_ang > aturn / 12 && tc[1:0] == 0) cur_ang--;
          ang_reg = cur_ang; aw = 1;
        end else if (tc == t6) begin
          tc++; pos_a = pos;
        end else if (tc < t9) begin
          tc++;
          if (cur_ang > 0 && tc[1:0] == 0) cur_ang--;
          ang_reg = cur_ang; aw = 1;
        end else if (tc == t9) begin
          tc++; pos_b = pos;
        end else begin
          // wiring check, then offset and initial angle
          dd = int'(pos_b) - int'(pos_a); hh = int'(half_cnt);
          if (wchk) begin
            if (!rev && ((dd > 0 && dd < hh) || (-dd > hh))) werr = 1;
            if (rev && ((-dd > 0 && -dd < hh) || (dd > hh))) werr = 1;
          end
          if (!werr) begin
            dv = 65536 / eff_poles();
            t = (cpr == ENC23_COUNTS) ? {16'd0, pos[22:7]} : {16'd0, pos[19:4]};
            if (rev) t = 65535 - t;
            t = t % dv;
            off_hold = t[15:0];
            init_hold = 12'((t * 3600 + (dv >> 1)) / dv);
          end
          ph = PH_RAMP_DOWN; tc = 0; cur_ang = 0; pos_a = 0; pos_b = 0;
        end
        tcnt = tc[19:0];
      end
      PH_RAMP_DOWN: begin
        if (dref > 0) dref = (dref >= 2) ? dref - 2 : 16'd0;
        else begin
          act = 0;
          if (sv != SERVO_RUN) begin
            tcnt = 0;
            if (!werr) begin
              ps = 1; ang_reg = off_hold; aw = 1; ph = PH_ENC_WRITE;
            end else ph = PH_DONE_FAIL;
          end
        end
      end
      PH_ENC_WRITE: begin
        er = 1;
        if (sav == SAVE_DONE) ph = PH_DONE_OK;
        else if (sav == SAVE_FAIL) ph = PH_DONE_FAIL;
      end
      default: begin
        if (ph == PH_DONE_OK) oc = OC_SUCCESS;
        else if (werr) oc = OC_WIRING;
        else oc = OC_FAIL;
        werr = 0; ph = PH_WAIT_READY;
      end
    endcase
    r.ctrl_word = (ph >= PH_WAIT_RUN && ph <= PH_ENC_WRITE) ? (cbase | CTRL_OVERRIDE) : cbase;
    r.pos_reset = (ph >= PH_SET_CTRL && ph <= PH_ENC_WRITE);
    r.d_current_ref = dref; r.angle_command = ang_reg; r.angle_write = aw;
    r.ident_active = act; r.offset_counts = off_hold; r.init_angle_tenths = init_hold;
    r.params_save = ps; r.encoder_write_req = er; r.outcome = oc;
  endtask

  always @(posedge clk) begin
    out_item_t exp_r, got;
    if (rst) begin
      cpr <= RST_COUNTS_PER_REV; poles <= RST_POLE_PAIRS; tps <= RST_TICKS_PER_SECOND;
      ilim <= RST_CURRENT_LIMIT; aturn <= RST_ANGLE_TURN_COUNT; rev <= RST_REVERSE_DIR;
      wchk <= RST_WIRING_CHECK_ON; cbase <= RST_CTRL_BASE;
      ph = PH_WAIT_READY; tcnt = 0; half_cnt = 0; cur_ang = 0; pos_a = 0; pos_b = 0;
      werr = 0; dref = 0; ang_reg = 0; act = 0; off_hold = 0; init_hold = 0;
      tick_results.delete(); fail_count <= 0; pending <= 0; tick_total <= 0;
      foreach (outcome_seen[k]) outcome_seen[k] <= 0;
    end else begin
      // register writes
      if (cfg_fire) case (cfg_item.reg_index)
        REG_COUNTS_PER_REV:   cpr <= cfg_item.wdata;
        REG_POLE_PAIRS:       poles <= cfg_item.wdata[6:0];
        REG_TICKS_PER_SECOND: tps <= cfg_item.wdata[15:0];
        REG_CURRENT_LIMIT:    ilim <= cfg_item.wdata[15:0];
        REG_ANGLE_TURN_COUNT: aturn <= cfg_item.wdata[15:0];
        REG_REVERSE_DIR:      rev <= cfg_item.wdata[0];
        REG_WIRING_CHECK_ON:  wchk <= cfg_item.wdata[0];
        default:              cbase <= cfg_item.wdata[15:0];
      endcase
      if (in_fire) begin
        run_tick(in_item, exp_r);
        tick_results.push_back(exp_r);
        tick_total <= tick_total + 1;
      end
      // compare with the oldest prediction
      if (out_fire) begin
        got = out_item;
        if (tick_results.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = tick_results.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            if (got.outcome !== exp_r.outcome)
              $display("  outcome expected %0d actual %0d", exp_r.outcome, got.outcome);
            fail_count <= fail_count + 1;
          end
          outcome_seen[exp_r.outcome] <= outcome_seen[exp_r.outcome] + 1;
        end
      end
      pending <= tick_results.size();
    end
  end

endmodule

// File: tb/tb_abs_encoder_angle_ident.sv
// Testbench top for abs_encoder_angle_ident: drives control ticks and register
// writes with random idling and gives the verdict. Depends on aeai_pkg,
// aeai_chan_if and aeai_checker.
`timescale 1ns / 1ps
module tb_abs_encoder_angle_ident;
  import aeai_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 0, rst = 1;
  int   idle_in_pct = 0, idle_out_pct = 0;
  longint cycles = 0;
  int   fails, pending, ticks, oc_seen[4];
  int   wiring_phase;

  aeai_chan_if #(in_item_t)  in_ch();
  aeai_chan_if #(out_item_t) out_ch();
  aeai_chan_if #(cfg_item_t) cfg_ch();

  abs_encoder_angle_ident i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
                                 .cfg_ch(cfg_ch));

  aeai_checker i_chk (
    .clk(clk), .rst(rst),
    .in_fire(in_ch.valid && in_ch.ready), .in_item(in_ch.data),
    .out_fire(out_ch.valid && out_ch.ready), .out_item(out_ch.data),
    .cfg_fire(cfg_ch.valid && cfg_ch.ready), .cfg_item(cfg_ch.data),
    .fail_count(fails), .pending(pending), .tick_total(ticks), .outcome_seen(oc_seen));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0; in_ch.data = '0; out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.data = '0;
  end

  // random stall on the result side
  always @(posedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= idle_out_pct);

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("abs_encoder_angle_ident verification failed");
      $finish;
    end
  end

  // track from each taken result item whether identification is active or current is applied
  always @(posedge clk)
    if (rst) wiring_phase <= 0;
    else if (out_ch.valid && out_ch.ready)
      wiring_phase <= out_ch.data.ident_active || out_ch.data.d_current_ref != 0;

  function automatic bit i_chk_phase_is_align_or_down();
    return wiring_phase != 0;
  endfunction

  // hold the item until taken, drop valid for the busy cycle, then idle at random
  task automatic send_tick(input logic [1:0] sv, input logic [22:0] pos,
                           input logic [1:0] sav);
    in_ch.valid <= 1;
    in_ch.data <= '{servo_state: sv, abs_position: pos, save_status: sav};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    in_ch.valid <= 0;
    @(posedge clk);
    while ($urandom_range(99) < idle_in_pct) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.data <= '{reg_index: idx, wdata: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
    @(posedge clk);
  endtask

  // drain the result queue, then let the block settle
  task automatic settle();
    while (pending != 0 || (in_ch.valid)) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic noise_tick();
    send_tick(2'($urandom_range(3)), 23'($urandom), 2'($urandom_range(3)));
  endtask

  // one full identification pass with random content and a few noise ticks
  task automatic run_sequence(input int n_before);
    logic [22:0] p;
    int hold;
    for (int i = 0; i < n_before; i++) noise_tick();
    send_tick(SERVO_READY, 23'($urandom), 2'($urandom_range(3)));
    send_tick(2'($urandom_range(3)), 23'($urandom), 2'd0);
    // a few ticks before the servo runs
    repeat ($urandom_range(2)) send_tick(2'(3 * $urandom_range(1)), 23'($urandom), 2'd0);
    send_tick(SERVO_RUN, 23'($urandom), 2'd0);
    p = 23'($urandom);
    hold = 0;
    // alignment, ramp down and wait for stop: servo keeps running a while
    while (i_chk_phase_is_align_or_down() && hold < 400) begin
      if ($urandom_range(3) == 0) p = 23'($urandom);
      else p = p + 23'($urandom_range(40000)) - 23'd20000;
      send_tick(($urandom_range(5) == 0) ? SERVO_READY : SERVO_RUN, p, 2'd0);
      hold++;
    end
    // stop the servo and answer the encoder write
    repeat (6) send_tick(SERVO_READY, 23'($urandom), 2'd0);
    send_tick(2'd0, 23'($urandom), 2'(1 + $urandom_range(1)));
    repeat (2) send_tick(2'd0, 23'($urandom), 2'($urandom_range(3)));
  endtask

  task automatic random_cfg();
    write_reg(REG_COUNTS_PER_REV, ($urandom_range(3) == 0) ? ENC23_COUNTS
                                  : 24'($urandom_range(1, 8388608)));
    write_reg(REG_POLE_PAIRS, 24'($urandom_range(0, 64)));
    write_reg(REG_TICKS_PER_SECOND, 24'($urandom_range(0, 4)));
    write_reg(REG_CURRENT_LIMIT, 24'($urandom_range(0, 40)));
    write_reg(REG_ANGLE_TURN_COUNT, 24'($urandom_range(1, 65535)));
    write_reg(REG_REVERSE_DIR, 24'($urandom_range(1)));
    write_reg(REG_WIRING_CHECK_ON, 24'($urandom_range(1)));
    write_reg(REG_CTRL_BASE, 24'($urandom_range(65535)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: a low and a high value for every register and input field, save fail, zero tick rate
    write_reg(REG_COUNTS_PER_REV, ENC23_COUNTS);
    write_reg(REG_POLE_PAIRS, 24'd0);
    write_reg(REG_TICKS_PER_SECOND, 24'd0);
    write_reg(REG_CURRENT_LIMIT, 24'd65535);
    write_reg(REG_ANGLE_TURN_COUNT, 24'd65535);
    write_reg(REG_REVERSE_DIR, 24'd1);
    write_reg(REG_WIRING_CHECK_ON, 24'd0);
    write_reg(REG_CTRL_BASE, 24'hffff);
    send_tick(2'd3, 23'h7fffff, 2'd3);
    send_tick(SERVO_READY, 23'h7fffff, 2'd3);
    send_tick(SERVO_RUN, 23'd0, 2'd0);
    send_tick(SERVO_RUN, 23'd0, 2'd0);
    repeat (3) send_tick(SERVO_RUN, 23'h7fffff, 2'd3);
    send_tick(SERVO_RUN, 23'h7fffff, 2'd0);
    send_tick(2'd0, 23'd0, 2'd0);
    send_tick(2'd3, 23'd0, 2'd0);
    repeat (3) send_tick(2'd0, 23'd0, 2'd3);
    send_tick(2'd0, 23'd0, SAVE_FAIL);
    send_tick(2'd0, 23'd0, 2'd0);
    settle();
    write_reg(REG_COUNTS_PER_REV, 24'd1);
    write_reg(REG_POLE_PAIRS, 24'd64);
    write_reg(REG_TICKS_PER_SECOND, 24'd1);
    write_reg(REG_CURRENT_LIMIT, 24'd0);
    write_reg(REG_ANGLE_TURN_COUNT, 24'd1);
    write_reg(REG_REVERSE_DIR, 24'd0);
    write_reg(REG_WIRING_CHECK_ON, 24'd1);
    write_reg(REG_CTRL_BASE, 24'd0);
    run_sequence(0);
    settle();

    // random: three idling regimes
    for (int mode = 0; mode < 3; mode++) begin
      idle_in_pct  = (mode == 0) ? 28 : (mode == 1) ? 87 : 0;
      idle_out_pct = (mode == 0) ? 87 : (mode == 1) ? 28 : 0;
      while (ticks < 540 * (mode + 1)) begin
        random_cfg();
        repeat (3) run_sequence($urandom_range(3));
        settle();
      end
    end
    settle();

    $display("Run covered %0d ticks; outcomes success %0d, wiring %0d, failure %0d.",
             ticks, oc_seen[OC_SUCCESS], oc_seen[OC_WIRING], oc_seen[OC_FAIL]);
    if (fails == 0 && pending == 0) begin
      $display("abs_encoder_angle_ident verification clean");
    end else begin
      $display("abs_encoder_angle_ident verification failed");
    end
    $finish;
  end

endmodule
